[hw/rtl/bhd_pkg.sv]
// Shared types, constants and the hold classifier for the button hold classifier.
`default_nettype none
package bhd_pkg;

  localparam int FIFO_DEPTH = 32;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CODE_W     = 3;
  localparam int CFG_W      = 8;
  localparam int IDX_W      = 2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);

  localparam logic             CMD_TICK = 1'b0;
  localparam logic             CMD_READ = 1'b1;

  localparam logic [IDX_W-1:0] REG_TICKS_PER_SEC = 2'd0;
  localparam logic [IDX_W-1:0] REG_REBOOT_SEC    = 2'd1;
  localparam logic [IDX_W-1:0] REG_FACTORY_SEC   = 2'd2;
  localparam logic [IDX_W-1:0] REG_WIPE_SEC      = 2'd3;

  localparam logic [CODE_W-1:0] EV_EDGE   = 3'd0;
  localparam logic [CODE_W-1:0] EV_CLASS1 = 3'd1;
  localparam logic [CODE_W-1:0] EV_CLASS2 = 3'd2;
  localparam logic [CODE_W-1:0] EV_CLASS3 = 3'd3;
  localparam logic [CODE_W-1:0] EV_CLASS4 = 3'd4;
  localparam logic [CODE_W-1:0] NO_CLASS  = 3'd7;

  localparam logic [7:0] MAX_SECONDS = 8'd255;

  typedef struct packed {
    logic [CFG_W-1:0] ticks_per_second;
    logic [CFG_W-1:0] reboot_seconds;
    logic [CFG_W-1:0] factory_seconds;
    logic [CFG_W-1:0] full_wipe_seconds;
  } cfg_t;

  typedef struct packed {
    logic              vld;
    logic [CODE_W-1:0] code;
  } push_t;

  function automatic logic [CODE_W-1:0] hold_class(input logic [7:0] secs, input cfg_t cfg);
    logic [CODE_W-1:0] cls;
    if (secs < cfg.reboot_seconds) begin
      cls = EV_CLASS1;
    end else if (secs < cfg.factory_seconds) begin
      cls = EV_CLASS2;
    end else if (secs < cfg.full_wipe_seconds) begin
      cls = EV_CLASS3;
    end else begin
      cls = EV_CLASS4;
    end
    return cls;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bhd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hw/rtl/bhd_tracker.sv]
// Press tracker: hold timing, classification and event generation per tick.
`default_nettype none
module bhd_tracker
  import bhd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  tick,
  input  wire logic  button_down,
  output push_t      push_a,
  output push_t      push_b
);

  logic              active_r, active_nxt;
  logic [7:0]        sub_r, sub_nxt;
  logic [7:0]        held_r, held_nxt;
  logic [CODE_W-1:0] last_r, last_nxt;
  logic [8:0]        sub_inc;
  logic [7:0]        held_upd;
  logic [CODE_W-1:0] cls;

  always_comb begin
    active_nxt = active_r;
    sub_nxt    = sub_r;
    held_nxt   = held_r;
    last_nxt   = last_r;
    push_a     = '{vld: 1'b0, code: EV_EDGE};
    push_b     = '{vld: 1'b0, code: EV_EDGE};
    sub_inc    = {1'b0, sub_r} + 9'd1;
    held_upd   = held_r;
    if (sub_inc >= {1'b0, cfg.ticks_per_second} && held_r != MAX_SECONDS) begin
      held_upd = held_r + 8'd1;
    end
    cls = hold_class(held_upd, cfg);
    if (tick) begin
      if (!active_r) begin
        if (button_down) begin
          push_a     = '{vld: 1'b1, code: EV_EDGE};
          active_nxt = 1'b1;
          sub_nxt    = '0;
          held_nxt   = '0;
          last_nxt   = NO_CLASS;
        end
      end else begin
        if (sub_inc >= {1'b0, cfg.ticks_per_second}) begin
          sub_nxt = '0;
        end else begin
          sub_nxt = sub_inc[7:0];
        end
        held_nxt = held_upd;
        if (cls != last_r) begin
          last_nxt = cls;
          push_a   = '{vld: 1'b1, code: cls};
        end
        if (!button_down) begin
          push_b     = '{vld: 1'b1, code: EV_EDGE};
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      sub_r    <= '0;
      held_r   <= '0;
      last_r   <= NO_CLASS;
    end else begin
      active_r <= active_nxt;
      sub_r    <= sub_nxt;
      held_r   <= held_nxt;
      last_r   <= last_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bhd_fifo.sv]
// Event FIFO around the event RAM, with read pipeline and output register.
`default_nettype none
module bhd_fifo
  import bhd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire push_t             push_a,
  input  wire push_t             push_b,
  input  wire logic              rd_req,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output logic      [CODE_W-1:0] out_code,
  output logic                   out_empty,
  output logic                   hold
);

  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic              a_vld_r, a_vld_nxt;
  logic              a_empty_r;
  logic              o_vld_r, o_vld_nxt;
  logic [CODE_W-1:0] o_code_r;
  logic              o_empty_r;
  logic              push_req;
  logic [CODE_W-1:0] push_code;
  logic              push_en;
  logic              pop_en;
  logic              a_adv;
  logic [CODE_W-1:0] rdata;

  always_comb begin
    push_req  = 1'b0;
    push_code = EV_EDGE;
    pend_nxt  = 1'b0;
    if (pend_r) begin
      push_req = 1'b1;
    end else if (push_a.vld) begin
      push_req  = 1'b1;
      push_code = push_a.code;
      pend_nxt  = push_b.vld;
    end else if (push_b.vld) begin
      push_req  = 1'b1;
      push_code = push_b.code;
    end
  end

  assign push_en = push_req && (cnt_r != DEPTH_CNT);
  assign pop_en  = rd_req && (cnt_r != '0);
  assign a_adv   = a_vld_r && (!o_vld_r || out_tready);
  assign hold    = pend_r || (a_vld_r && o_vld_r && !out_tready);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_en && !pop_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop_en && !push_en) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    a_vld_nxt = a_vld_r;
    if (rd_req) begin
      a_vld_nxt = 1'b1;
    end else if (a_adv) begin
      a_vld_nxt = 1'b0;
    end
    o_vld_nxt = o_vld_r;
    if (a_adv) begin
      o_vld_nxt = 1'b1;
    end else if (out_tready) begin
      o_vld_nxt = 1'b0;
    end
  end

  bhd_ram #(
    .WIDTH(CODE_W),
    .DEPTH(FIFO_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (push_en),
    .waddr(wr_ptr_r),
    .wdata(push_code),
    .re   (pop_en),
    .raddr(rd_ptr_r),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
      a_vld_r  <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      a_vld_r  <= a_vld_nxt;
      o_vld_r  <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req) begin
      a_empty_r <= (cnt_r == '0);
    end
    if (a_adv) begin
      o_code_r  <= a_empty_r ? EV_EDGE : rdata;
      o_empty_r <= a_empty_r;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_code   = o_code_r;
  assign out_empty  = o_empty_r;

endmodule
`default_nettype wire

[hw/rtl/button_hold_duration_classifier.sv]
// Top level of the button hold classifier: config registers, tracker and event FIFO.
//
//   port group | dir | carries
//   in_*       | in  | ticks (tuser=0, button level in tdata) and reads (tuser=1)
//   out_*      | out | one result per read: event code, empty flag
//   cfg_*      | in  | register writes, index 0..3
//
// One item per cycle while in_tready is high; a tick that both changes class and
// sees release writes two events through the single RAM write port and pauses
// input for the second write. A read result passes the RAM read and output register.
// Synchronous active-low reset; no clearing pass, the event RAM needs none.
// out_tready low with a result held and a read in flight drops in_tready.
`default_nettype none
module button_hold_duration_classifier
  import bhd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // [0] button_down, [7:1] zero
  input  wire logic [0:0]       in_tuser,   // [0] command
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [7:0]       out_tdata,  // [2:0] event_code, [7:3] zero
  output logic      [0:0]       out_tuser,  // [0] fifo_empty
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  cfg_t              cfg_r, cfg_nxt;
  logic              in_acc;
  logic              tick;
  logic              rd_req;
  logic              hold;
  push_t             push_a;
  push_t             push_b;
  logic [CODE_W-1:0] out_code;
  logic              out_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_TICKS_PER_SEC: cfg_nxt.ticks_per_second  = cfg_wdata;
        REG_REBOOT_SEC:    cfg_nxt.reboot_seconds    = cfg_wdata;
        REG_FACTORY_SEC:   cfg_nxt.factory_seconds   = cfg_wdata;
        REG_WIPE_SEC:      cfg_nxt.full_wipe_seconds = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{ticks_per_second: 8'd16, reboot_seconds: 8'd3,
                 factory_seconds: 8'd10, full_wipe_seconds: 8'd20};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !hold;
  assign in_acc    = in_tvalid && in_tready;
  assign tick      = in_acc && (in_tuser[0] == CMD_TICK);
  assign rd_req    = in_acc && (in_tuser[0] == CMD_READ);

  bhd_tracker u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .tick       (tick),
    .button_down(in_tdata[0]),
    .push_a     (push_a),
    .push_b     (push_b)
  );

  bhd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (push_a),
    .push_b    (push_b),
    .rd_req    (rd_req),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_code  (out_code),
    .out_empty (out_empty),
    .hold      (hold)
  );

  assign out_tdata = {5'd0, out_code};
  assign out_tuser = out_empty;

endmodule
`default_nettype wire

[tb/sv/hold_event_checker.sv]
// Checker for the button hold classifier: predicts the event queue and checks every read result.
`timescale 1ns / 100ps
module hold_event_checker
  import bhd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [7:0]       in_tdata,   // [0] button_down, [7:1] zero
  input  logic [0:0]       in_tuser,   // [0] command
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [7:0]       out_tdata,  // [2:0] event_code, [7:3] zero
  input  logic [0:0]       out_tuser,  // [0] fifo_empty
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               errors,
  output int               results_due,
  output int               results_checked,
  output int               events_dropped
);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              empty;
  } read_result_t;

  logic [CFG_W-1:0]  ticks_per_sec = 8'd16;
  logic [CFG_W-1:0]  reboot_secs   = 8'd3;
  logic [CFG_W-1:0]  factory_secs  = 8'd10;
  logic [CFG_W-1:0]  wipe_secs     = 8'd20;
  logic              pressing      = 1'b0;
  logic [7:0]        sub_ticks     = '0;
  logic [7:0]        held_secs     = '0;
  logic [CODE_W-1:0] last_cls      = NO_CLASS;
  logic [CODE_W-1:0] queued_events[$];
  read_result_t      expected_reads[$];
  read_result_t      want;
  int                fail_count = 0;
  int                checked    = 0;
  int                dropped    = 0;

  function automatic logic [CODE_W-1:0] class_of(input logic [7:0] secs);
    if (secs < reboot_secs) begin
      return EV_CLASS1;
    end
    if (secs < factory_secs) begin
      return EV_CLASS2;
    end
    if (secs < wipe_secs) begin
      return EV_CLASS3;
    end
    return EV_CLASS4;
  endfunction

  function automatic void store_event(input logic [CODE_W-1:0] code);
    if (queued_events.size() < FIFO_DEPTH) begin
      queued_events.push_back(code);
    end else begin
      dropped++;
    end
  endfunction

  function automatic void advance_tick(input logic down);
    logic [8:0]        next_ticks;
    logic [CODE_W-1:0] cls;
    if (!pressing) begin
      if (down) begin
        store_event(EV_EDGE);
        pressing  = 1'b1;
        sub_ticks = '0;
        held_secs = '0;
        last_cls  = NO_CLASS;
      end
      return;
    end
    next_ticks = {1'b0, sub_ticks} + 9'd1;
    if (next_ticks >= {1'b0, ticks_per_sec}) begin
      next_ticks = '0;
      if (held_secs != MAX_SECONDS) begin
        held_secs = held_secs + 8'd1;
      end
    end
    sub_ticks = next_ticks[7:0];
    cls = class_of(held_secs);
    if (cls != last_cls) begin
      last_cls = cls;
      store_event(cls);
    end
    if (!down) begin
      store_event(EV_EDGE);
      pressing = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_sec = 8'd16;
      reboot_secs   = 8'd3;
      factory_secs  = 8'd10;
      wipe_secs     = 8'd20;
      pressing      = 1'b0;
      sub_ticks     = '0;
      held_secs     = '0;
      last_cls      = NO_CLASS;
      queued_events.delete();
      expected_reads.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TICKS_PER_SEC: ticks_per_sec = cfg_wdata;
          REG_REBOOT_SEC:    reboot_secs   = cfg_wdata;
          REG_FACTORY_SEC:   factory_secs  = cfg_wdata;
          REG_WIPE_SEC:      wipe_secs     = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_reads.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, got code %0d empty %0b",
                   $time, out_tdata[CODE_W-1:0], out_tuser[0]);
        end else begin
          want = expected_reads.pop_front();
          checked++;
          if (out_tdata[CODE_W-1:0] !== want.code) begin
            fail_count++;
            $display("%0t: event_code mismatch: expected %0d, got %0d",
                     $time, want.code, out_tdata[CODE_W-1:0]);
          end
          if (out_tuser[0] !== want.empty) begin
            fail_count++;
            $display("%0t: fifo_empty mismatch: expected %0b, got %0b",
                     $time, want.empty, out_tuser[0]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == CMD_READ) begin
          if (queued_events.size() == 0) begin
            want.code  = EV_EDGE;
            want.empty = 1'b1;
          end else begin
            want.code  = queued_events.pop_front();
            want.empty = 1'b0;
          end
          expected_reads.push_back(want);
        end else begin
          advance_tick(in_tdata[0]);
        end
      end
    end
    errors          <= fail_count;
    results_due     <= expected_reads.size();
    results_checked <= checked;
    events_dropped  <= dropped;
  end

endmodule

[tb/sv/tb_button_hold_duration_classifier.sv]
// Testbench top for the button hold classifier: stimulus, register settings and verdict.
`timescale 1ns / 100ps
module tb_button_hold_duration_classifier;
  import bhd_pkg::*;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata  = '0;        // [0] button_down, [7:1] zero
  logic [0:0]       in_tuser  = CMD_TICK;  // [0] command
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;             // [2:0] event_code, [7:3] zero
  logic [0:0]       out_tuser;             // [0] fifo_empty
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_TICKS_PER_SEC;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int errors;
  int results_due;
  int results_checked;
  int events_dropped;
  int items_sent = 0;
  int reads_sent = 0;
  int settings   = 0;
  int read_pct   = 30;
  bit tx_steady  = 1'b0;
  bit rx_steady  = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  button_hold_duration_classifier DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  hold_event_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .errors          (errors),
    .results_due     (results_due),
    .results_checked (results_checked),
    .events_dropped  (events_dropped)
  );

  function automatic int idle_cycles(input bit steady);
    if (steady) begin
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic send_item(input logic cmd, input logic down);
    int gap;
    gap = idle_cycles(tx_steady);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, down};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (cmd == CMD_READ) begin
      reads_sent++;
    end
  endtask

  task automatic maybe_read();
    if ($urandom_range(0, 99) < read_pct) begin
      send_item(CMD_READ, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic press_run(input int hold_ticks);
    maybe_read();
    send_item(CMD_TICK, 1'b1);
    repeat (hold_ticks) begin
      maybe_read();
      send_item(CMD_TICK, 1'b1);
    end
    maybe_read();
    send_item(CMD_TICK, 1'b0);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] tps, input logic [CFG_W-1:0] reboot,
                            input logic [CFG_W-1:0] factory, input logic [CFG_W-1:0] wipe);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TICKS_PER_SEC;
    cfg_wdata <= tps;
    @(posedge clk);
    cfg_index <= REG_REBOOT_SEC;
    cfg_wdata <= reboot;
    @(posedge clk);
    cfg_index <= REG_FACTORY_SEC;
    cfg_wdata <= factory;
    @(posedge clk);
    cfg_index <= REG_WIPE_SEC;
    cfg_wdata <= wipe;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    int gap;
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        rx_steady = !rx_steady;
      end
      gap = idle_cycles(rx_steady);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int phase;
    int mark;
    int pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty reads, ignored level on a read, idle tick, one short press
    send_item(CMD_READ, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_READ, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b0);
    repeat (4) send_item(CMD_READ, 1'b0);
    settle();

    // one second per tick: walk through classes 2 to 4, last change on the release tick
    set_config(8'd1, 8'd1, 8'd2, 8'd3);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_TICK, 1'b0);
    repeat (6) send_item(CMD_READ, 1'b0);
    settle();

    for (phase = 1; items_sent < 820; phase++) begin
      case (phase)
        1:       set_config(8'd1, 8'd2, 8'd4, 8'd6);
        2:       set_config(8'd1, 8'd1, 8'd1, 8'd1);
        3:       set_config(8'd255, 8'd255, 8'd255, 8'd255);
        4:       set_config(8'd2, 8'd5, 8'd3, 8'd8);
        5:       set_config(8'd1, 8'd1, 8'd100, 8'd255);
        default: set_config(8'($urandom_range(1, 4)), 8'($urandom_range(1, 10)),
                            8'($urandom_range(1, 10)), 8'($urandom_range(1, 10)));
      endcase
      if (phase == 5) begin
        // hold past the seconds ceiling
        read_pct = 2;
        press_run(262);
      end
      mark = items_sent;
      while (items_sent - mark < 100) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        read_pct  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(10, 60);
        pick      = $urandom_range(0, 9);
        if (pick < 6) begin
          press_run(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(0, 12));
        end else if (pick < 8) begin
          repeat ($urandom_range(1, 40)) send_item(CMD_READ, 1'($urandom_range(0, 1)));
        end else if (pick == 8) begin
          repeat ($urandom_range(1, 8)) begin
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end else begin
          // flood the queue with short presses and no reads
          read_pct = 0;
          repeat (14) press_run($urandom_range(0, 2));
        end
      end
      settle();
    end

    $display("Covered %0d items (%0d reads) over %0d register settings, holds up to 262 ticks.",
             items_sent, reads_sent, settings);
    $display("Compared %0d read results; %0d events fell on a full queue.",
             results_checked, events_dropped);
    if (errors == 0 && results_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
